// ===== rtl/core/bcpi_pkg.sv =====
// Shared types, constants and saturation helpers for the balance PD / speed PI controller.
// No dependencies; used by the interfaces, the multiplier, the top level and the checker.
`default_nettype none

package bcpi_pkg;

   localparam int ANGLE_W    = 17;
   localparam int RATE_W     = 16;
   localparam int COUNT_W    = 16;
   localparam int GAIN_W     = 24;
   localparam int DRIVE_W    = 16;
   localparam int TERM_W     = 32;
   localparam int FILTER_W   = 26;
   localparam int INTEG_W    = 23;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 30;
   localparam int MUL_B_W = 29;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 52;

   // Divide-by-5: floor(2^30 / 5), estimate is exact or one low.
   localparam int          DIV_SHIFT = 30;
   localparam logic [27:0] DIV_MAGIC = 28'd214748364;

   localparam logic signed [26:0] INTEG_MAX = 27'sd2560000;
   localparam logic signed [26:0] INTEG_MIN = -27'sd2560000;

   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_PGAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_IGAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT    = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANG_MUL,
      ST_RATE_MUL,
      ST_RATE_ACC,
      ST_ANG_TERM,
      ST_DIV_MUL,
      ST_DIV_FIX,
      ST_INTEG,
      ST_PROP_MUL,
      ST_INTG_MUL,
      ST_INTG_ACC,
      ST_SPD_TERM,
      ST_DONE
   } state_type;

   // Q.16 accumulator to integer, truncated toward zero, saturated to 32 bits.
   function automatic logic signed [TERM_W-1:0] trunc_sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] biased;
      logic signed [ACC_W-17:0] q;
      logic signed [TERM_W-1:0] r;
      biased = v + (v[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0));
      q = biased[ACC_W-1:16];
      if (q > (ACC_W-16)'(64'sh7FFFFFFF)) begin
         r = 32'sh7FFFFFFF;
      end else if (q < -(ACC_W-16)'(64'sh80000000)) begin
         r = 32'sh80000000;
      end else begin
         r = q[TERM_W-1:0];
      end
      return r;
   endfunction

   // Difference of two terms saturated to the 16-bit drive range.
   function automatic logic signed [DRIVE_W-1:0] drive_sat(input logic signed [TERM_W-1:0] a,
                                                           input logic signed [TERM_W-1:0] s);
      logic signed [TERM_W:0] d;
      logic signed [DRIVE_W-1:0] r;
      d = {a[TERM_W-1], a} - {s[TERM_W-1], s};
      if (d > 33'sd32767) begin
         r = 16'sh7FFF;
      end else if (d < -33'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = d[DRIVE_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bcpi_if.sv =====
// Valid/ready channel interfaces for sensor ticks and drive results.
// Depends on bcpi_pkg for field widths.
`default_nettype none

interface bcpi_req_if;
   logic valid;
   logic ready;
   logic signed [bcpi_pkg::ANGLE_W-1:0] tilt_angle;
   logic signed [bcpi_pkg::RATE_W-1:0]  tilt_rate;
   logic signed [bcpi_pkg::COUNT_W-1:0] left_count;
   logic signed [bcpi_pkg::COUNT_W-1:0] right_count;

   modport source(output valid, tilt_angle, tilt_rate, left_count, right_count, input ready);
   modport sink(input valid, tilt_angle, tilt_rate, left_count, right_count, output ready);
endinterface

interface bcpi_rsp_if;
   logic valid;
   logic ready;
   logic signed [bcpi_pkg::DRIVE_W-1:0] motor_drive;
   logic signed [bcpi_pkg::TERM_W-1:0]  angle_term;
   logic signed [bcpi_pkg::TERM_W-1:0]  speed_term;

   modport source(output valid, motor_drive, angle_term, speed_term, input ready);
   modport sink(input valid, motor_drive, angle_term, speed_term, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bcpi_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on bcpi_pkg for operand widths.
`default_nettype none

module bcpi_mul (
   input  wire logic                                clock,
   input  wire logic signed [bcpi_pkg::MUL_A_W-1:0] op_a,
   input  wire logic signed [bcpi_pkg::MUL_B_W-1:0] op_b,
   output logic signed [bcpi_pkg::PROD_W-1:0]       prod
);

   logic signed [bcpi_pkg::PROD_W-1:0] prod_ff;
   logic signed [bcpi_pkg::PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/balance_pd_speed_pi_controller.sv =====
// Top level: cascaded angle PD / wheel-speed PI balance controller.
// Depends on bcpi_pkg, bcpi_if (channels) and bcpi_mul (shared multiplier).
//
// Usage:
//  - req_chan carries one sensor tick per transfer (tilt angle, gyro rate, two
//    encoder deltas). rsp_chan carries the drive value and both terms.
//  - Ticks alternate: the first tick after reset only flips the phase and gives
//    no result; the next one computes. A non-computing tick leaves the
//    sequencer idle, so the block is ready again in the next cycle.
//  - A computing tick runs through a 12-step sequencer around one shared
//    30x29 multiplier (angle, rate, divide-by-5, speed P, speed I products).
//    Its result enters the output register when the last step ends, and
//    req_chan.ready is low while the sequencer runs.
//  - The result sits in an output register. A new tick is taken while it waits;
//    a later result waits in the last sequencer step until the register frees.
//    A stalled receiver holds the payload steady.
//  - csr_* writes gains and setpoint (index 0..4); other indexes are ignored.
//    Write only while idle.
//  - reset (synchronous, active high) clears gains, setpoint, phase, filter,
//    integral and the output valid flag.
`default_nettype none

module balance_pd_speed_pi_controller (
   input  wire logic                              clock,
   input  wire logic                              reset,
   bcpi_req_if.sink                               req_chan,
   bcpi_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [bcpi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bcpi_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // configuration
   logic signed [bcpi_pkg::GAIN_W-1:0]  angle_gain_ff, rate_gain_ff;
   logic signed [bcpi_pkg::GAIN_W-1:0]  speed_pgain_ff, speed_igain_ff;
   logic signed [bcpi_pkg::ANGLE_W-1:0] setpoint_ff;

   // sequencer and controller state
   bcpi_pkg::state_type state_ff, state_in;
   logic phase_ff, phase_in;
   logic signed [bcpi_pkg::FILTER_W-1:0] filter_ff, filter_in;
   logic signed [bcpi_pkg::INTEG_W-1:0]  integral_ff, integral_in;

   // latched tick
   logic signed [bcpi_pkg::ANGLE_W-1:0] angle_ff, angle_in;
   logic signed [bcpi_pkg::RATE_W-1:0]  rate_ff, rate_in;
   logic signed [bcpi_pkg::COUNT_W:0]   sum_ff, sum_in;

   // working registers
   logic signed [bcpi_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [bcpi_pkg::TERM_W-1:0] aterm_ff, aterm_in;
   logic signed [bcpi_pkg::TERM_W-1:0] sterm_ff, sterm_in;
   logic [bcpi_pkg::MUL_B_W-1:0]       div_mag_ff, div_mag_in;
   logic                               div_neg_ff, div_neg_in;

   // output register
   logic                                out_valid_ff, out_valid_in;
   logic signed [bcpi_pkg::DRIVE_W-1:0] out_drive_ff, out_drive_in;
   logic signed [bcpi_pkg::TERM_W-1:0]  out_aterm_ff, out_aterm_in;
   logic signed [bcpi_pkg::TERM_W-1:0]  out_sterm_ff, out_sterm_in;

   // shared multiplier
   logic signed [bcpi_pkg::MUL_A_W-1:0] mul_a;
   logic signed [bcpi_pkg::MUL_B_W-1:0] mul_b;
   logic signed [bcpi_pkg::PROD_W-1:0]  prod;

   logic req_xfer, rsp_xfer;
   logic signed [bcpi_pkg::ANGLE_W:0] err;

   // filter input 4*old + 256*sum, its magnitude
   logic signed [bcpi_pkg::MUL_B_W-1:0] fsum;
   // divide fixup
   logic [27:0] quot_est, quot;
   logic [30:0] rem;
   logic signed [28:0] quot_signed;
   logic signed [26:0] integ_sum;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (state_ff == bcpi_pkg::ST_IDLE);

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.motor_drive = out_drive_ff;
   assign rsp_chan.angle_term  = out_aterm_ff;
   assign rsp_chan.speed_term  = out_sterm_ff;

   assign err = {angle_ff[bcpi_pkg::ANGLE_W-1], angle_ff}
              - {setpoint_ff[bcpi_pkg::ANGLE_W-1], setpoint_ff};

   assign fsum = {{1{filter_ff[bcpi_pkg::FILTER_W-1]}}, filter_ff, 2'b00}
               + {{4{sum_ff[bcpi_pkg::COUNT_W]}}, sum_ff, 8'h00};

   // Estimate is floor or one below; one compare fixes it.
   assign quot_est    = prod[bcpi_pkg::DIV_SHIFT+27:bcpi_pkg::DIV_SHIFT];
   assign rem         = {2'b00, div_mag_ff} - ({1'b0, quot_est, 2'b00} + {3'b000, quot_est});
   assign quot        = quot_est + ((rem >= 31'd5) ? 28'd1 : 28'd0);
   assign quot_signed = div_neg_ff ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

   assign integ_sum = {{4{integral_ff[bcpi_pkg::INTEG_W-1]}}, integral_ff}
                    + {{1{filter_ff[bcpi_pkg::FILTER_W-1]}}, filter_ff};

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         bcpi_pkg::ST_ANG_MUL: begin
            mul_a = {{6{angle_gain_ff[23]}}, angle_gain_ff};
            mul_b = {{11{err[17]}}, err};
         end
         bcpi_pkg::ST_RATE_MUL: begin
            mul_a = {{6{rate_gain_ff[23]}}, rate_gain_ff};
            mul_b = {{13{rate_ff[15]}}, rate_ff};
         end
         bcpi_pkg::ST_DIV_MUL: begin
            mul_a = {1'b0, div_mag_ff};
            mul_b = {1'b0, bcpi_pkg::DIV_MAGIC};
         end
         bcpi_pkg::ST_PROP_MUL: begin
            mul_a = {{6{speed_pgain_ff[23]}}, speed_pgain_ff};
            mul_b = {{3{filter_ff[25]}}, filter_ff};
         end
         bcpi_pkg::ST_INTG_MUL: begin
            mul_a = {{6{speed_igain_ff[23]}}, speed_igain_ff};
            mul_b = {{6{integral_ff[22]}}, integral_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   bcpi_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // sequencer: next state and datapath
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      filter_in    = filter_ff;
      integral_in  = integral_ff;
      angle_in     = angle_ff;
      rate_in      = rate_ff;
      sum_in       = sum_ff;
      acc_in       = acc_ff;
      aterm_in     = aterm_ff;
      sterm_in     = sterm_ff;
      div_mag_in   = div_mag_ff;
      div_neg_in   = div_neg_ff;
      out_valid_in = out_valid_ff && !rsp_xfer;
      out_drive_in = out_drive_ff;
      out_aterm_in = out_aterm_ff;
      out_sterm_in = out_sterm_ff;

      unique case (state_ff)
         bcpi_pkg::ST_IDLE: begin
            if (req_xfer) begin
               phase_in = !phase_ff;
               angle_in = req_chan.tilt_angle;
               rate_in  = req_chan.tilt_rate;
               sum_in   = {req_chan.right_count[15], req_chan.right_count}
                        - {req_chan.left_count[15], req_chan.left_count};
               // phase set by this tick means no result
               if (phase_ff) begin
                  state_in = bcpi_pkg::ST_ANG_MUL;
               end
            end
         end
         bcpi_pkg::ST_ANG_MUL: begin
            state_in = bcpi_pkg::ST_RATE_MUL;
         end
         bcpi_pkg::ST_RATE_MUL: begin
            acc_in   = prod[bcpi_pkg::ACC_W-1:0];
            state_in = bcpi_pkg::ST_RATE_ACC;
         end
         bcpi_pkg::ST_RATE_ACC: begin
            // gyro rate is an integer: scale its product by 256 to Q.16
            acc_in   = acc_ff + {prod[bcpi_pkg::ACC_W-9:0], 8'h00};
            state_in = bcpi_pkg::ST_ANG_TERM;
         end
         bcpi_pkg::ST_ANG_TERM: begin
            aterm_in   = bcpi_pkg::trunc_sat32(acc_ff);
            div_neg_in = fsum[bcpi_pkg::MUL_B_W-1];
            div_mag_in = fsum[bcpi_pkg::MUL_B_W-1] ? 29'(-fsum) : 29'(fsum);
            state_in   = bcpi_pkg::ST_DIV_MUL;
         end
         bcpi_pkg::ST_DIV_MUL: begin
            state_in = bcpi_pkg::ST_DIV_FIX;
         end
         bcpi_pkg::ST_DIV_FIX: begin
            filter_in = quot_signed[bcpi_pkg::FILTER_W-1:0];
            state_in  = bcpi_pkg::ST_INTEG;
         end
         bcpi_pkg::ST_INTEG: begin
            priority if (integ_sum > bcpi_pkg::INTEG_MAX) begin
               integral_in = bcpi_pkg::INTEG_MAX[bcpi_pkg::INTEG_W-1:0];
            end else if (integ_sum < bcpi_pkg::INTEG_MIN) begin
               integral_in = bcpi_pkg::INTEG_MIN[bcpi_pkg::INTEG_W-1:0];
            end else begin
               integral_in = integ_sum[bcpi_pkg::INTEG_W-1:0];
            end
            state_in = bcpi_pkg::ST_PROP_MUL;
         end
         bcpi_pkg::ST_PROP_MUL: begin
            state_in = bcpi_pkg::ST_INTG_MUL;
         end
         bcpi_pkg::ST_INTG_MUL: begin
            acc_in   = prod[bcpi_pkg::ACC_W-1:0];
            state_in = bcpi_pkg::ST_INTG_ACC;
         end
         bcpi_pkg::ST_INTG_ACC: begin
            acc_in   = acc_ff + prod[bcpi_pkg::ACC_W-1:0];
            state_in = bcpi_pkg::ST_SPD_TERM;
         end
         bcpi_pkg::ST_SPD_TERM: begin
            sterm_in = bcpi_pkg::trunc_sat32(acc_ff);
            state_in = bcpi_pkg::ST_DONE;
         end
         bcpi_pkg::ST_DONE: begin
            // wait here until the output register is free
            if (!out_valid_ff || rsp_xfer) begin
               out_valid_in = 1'b1;
               out_drive_in = bcpi_pkg::drive_sat(aterm_ff, sterm_ff);
               out_aterm_in = aterm_ff;
               out_sterm_in = sterm_ff;
               state_in     = bcpi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bcpi_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcpi_pkg::ST_IDLE;
         phase_ff     <= 1'b0;
         filter_ff    <= '0;
         integral_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         filter_ff    <= filter_in;
         integral_ff  <= integral_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff     <= angle_in;
      rate_ff      <= rate_in;
      sum_ff       <= sum_in;
      acc_ff       <= acc_in;
      aterm_ff     <= aterm_in;
      sterm_ff     <= sterm_in;
      div_mag_ff   <= div_mag_in;
      div_neg_ff   <= div_neg_in;
      out_drive_ff <= out_drive_in;
      out_aterm_ff <= out_aterm_in;
      out_sterm_ff <= out_sterm_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_gain_ff  <= '0;
         rate_gain_ff   <= '0;
         speed_pgain_ff <= '0;
         speed_igain_ff <= '0;
         setpoint_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            bcpi_pkg::REG_ANGLE_GAIN:  angle_gain_ff  <= csr_wdata;
            bcpi_pkg::REG_RATE_GAIN:   rate_gain_ff   <= csr_wdata;
            bcpi_pkg::REG_SPEED_PGAIN: speed_pgain_ff <= csr_wdata;
            bcpi_pkg::REG_SPEED_IGAIN: speed_igain_ff <= csr_wdata;
            bcpi_pkg::REG_SETPOINT:    setpoint_ff    <= csr_wdata[bcpi_pkg::ANGLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/bcpi_checker.sv =====
// Port-level checks for the balance controller, bound to the top level.
// Depends on bcpi_pkg for widths and the drive saturation function.
`default_nettype none

module bcpi_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic signed [bcpi_pkg::DRIVE_W-1:0] motor_drive,
   input wire logic signed [bcpi_pkg::TERM_W-1:0]  angle_term,
   input wire logic signed [bcpi_pkg::TERM_W-1:0]  speed_term
);

   logic req_xfer;
   logic phase_ff, phase_in;

   assign req_xfer = req_valid && req_ready;
   assign phase_in = req_xfer ? !phase_ff : phase_ff;

   // mirror of the tick phase seen at the ports
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(motor_drive))
      else $error("result changed while stalled");

   a_drive_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> motor_drive == bcpi_pkg::drive_sat(angle_term, speed_term))
      else $error("drive does not match its terms");

   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer && phase_ff |=> !req_ready)
      else $error("ready during computation");

   a_skip_ready: assert property (@(posedge clock) disable iff (reset)
      req_xfer && !phase_ff |=> req_ready && !$rose(rsp_valid))
      else $error("skipped tick stalled input or gave a result");

endmodule

bind balance_pd_speed_pi_controller bcpi_checker u_bcpi_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .motor_drive (rsp_chan.motor_drive),
   .angle_term  (rsp_chan.angle_term),
   .speed_term  (rsp_chan.speed_term)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking bench for balance_pd_speed_pi_controller: sensor ticks and gain writes in,
// drive values and both loop terms checked against a fixed-point model kept in the bench.
// Depends on bcpi_pkg, bcpi_if (req/rsp channels) and the controller RTL.
`timescale 1ns / 100ps

// Saturation limits and clamp used by the bench model
localparam longint TERM_MAX          = 64'sh7FFFFFFF;
localparam longint TERM_MIN          = -64'sh80000000;
localparam longint DRIVE_MAX         = 32767;
localparam longint DRIVE_MIN         = -32768;
localparam longint SPEED_INTEG_LIMIT = 2560000;   // 10000.0 in Q.8

typedef struct {
   logic signed [bcpi_pkg::ANGLE_W-1:0] tilt_angle;
   logic signed [bcpi_pkg::RATE_W-1:0]  tilt_rate;
   logic signed [bcpi_pkg::COUNT_W-1:0] left_count;
   logic signed [bcpi_pkg::COUNT_W-1:0] right_count;
} tick_type;

typedef struct {
   logic signed [bcpi_pkg::DRIVE_W-1:0] motor_drive;
   logic signed [bcpi_pkg::TERM_W-1:0]  angle_term;
   logic signed [bcpi_pkg::TERM_W-1:0]  speed_term;
} drive_type;

class drive_scoreboard;
   longint angle_gain, rate_gain, speed_pgain, speed_igain, setpoint;
   bit     skip_phase;
   longint speed_filter, speed_integral;
   drive_type expected_drives[$];
   int     mismatches, ticks_seen, drives_checked;
   int     integ_clamps, term_sats, drive_sats;

   function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function int pending();
      return expected_drives.size();
   endfunction

   // Gains are 24-bit signed, setpoint keeps its low 17 bits; unknown indexes drop out
   function void write_reg(logic [bcpi_pkg::CSR_IDX_W-1:0] idx,
                           logic [bcpi_pkg::CSR_DATA_W-1:0] data);
      logic signed [bcpi_pkg::GAIN_W-1:0]  gain;
      logic signed [bcpi_pkg::ANGLE_W-1:0] sp;
      gain = data;
      sp   = data[bcpi_pkg::ANGLE_W-1:0];
      case (idx)
         bcpi_pkg::REG_ANGLE_GAIN:  angle_gain  = gain;
         bcpi_pkg::REG_RATE_GAIN:   rate_gain   = gain;
         bcpi_pkg::REG_SPEED_PGAIN: speed_pgain = gain;
         bcpi_pkg::REG_SPEED_IGAIN: speed_igain = gain;
         bcpi_pkg::REG_SETPOINT:    setpoint    = sp;
         default: ;
      endcase
   endfunction

   // One accepted tick: flip phase, and on a computing tick queue the expected drive
   function void note_tick(tick_type t);
      longint angle, rate, sum, raw, aterm, sterm, drv;
      logic signed [bcpi_pkg::FILTER_W-1:0] filt_bits;
      logic signed [bcpi_pkg::INTEG_W-1:0]  integ_bits;
      drive_type want;
      ticks_seen++;
      skip_phase = !skip_phase;
      if (skip_phase) return;

      angle = t.tilt_angle;
      rate  = t.tilt_rate;
      raw   = (angle_gain * (angle - setpoint) + rate_gain * rate * 256) / 65536;
      aterm = clamp(raw, TERM_MIN, TERM_MAX);
      if (aterm != raw) term_sats++;

      // 0.8*old + 0.2*sum in Q.8, kept to the filter register width
      sum       = longint'(t.right_count) - longint'(t.left_count);
      raw       = (4 * speed_filter + sum * 256) / 5;
      filt_bits = raw[bcpi_pkg::FILTER_W-1:0];
      speed_filter = filt_bits;
      raw        = speed_integral + speed_filter;
      if (raw > SPEED_INTEG_LIMIT || raw < -SPEED_INTEG_LIMIT) integ_clamps++;
      raw        = clamp(raw, -SPEED_INTEG_LIMIT, SPEED_INTEG_LIMIT);
      integ_bits = raw[bcpi_pkg::INTEG_W-1:0];
      speed_integral = integ_bits;

      raw   = (speed_pgain * speed_filter + speed_igain * speed_integral) / 65536;
      sterm = clamp(raw, TERM_MIN, TERM_MAX);
      if (sterm != raw) term_sats++;

      drv = clamp(aterm - sterm, DRIVE_MIN, DRIVE_MAX);
      if (drv != aterm - sterm) drive_sats++;

      want.motor_drive = drv[bcpi_pkg::DRIVE_W-1:0];
      want.angle_term  = aterm[bcpi_pkg::TERM_W-1:0];
      want.speed_term  = sterm[bcpi_pkg::TERM_W-1:0];
      expected_drives.push_back(want);
   endfunction

   function void check_result(drive_type got);
      drive_type want;
      if (expected_drives.size() == 0) begin
         $error("unexpected result: motor_drive %0d angle_term %0d speed_term %0d",
                got.motor_drive, got.angle_term, got.speed_term);
         mismatches++;
         return;
      end
      want = expected_drives.pop_front();
      drives_checked++;
      if (got.motor_drive !== want.motor_drive) begin
         $error("motor_drive: expected %0d, actual %0d", want.motor_drive, got.motor_drive);
         mismatches++;
      end
      if (got.angle_term !== want.angle_term) begin
         $error("angle_term: expected %0d, actual %0d", want.angle_term, got.angle_term);
         mismatches++;
      end
      if (got.speed_term !== want.speed_term) begin
         $error("speed_term: expected %0d, actual %0d", want.speed_term, got.speed_term);
         mismatches++;
      end
   endfunction
endclass

module tb_top;

   localparam int     ANGLE_LIM       = 46080;        // 180 deg in Q8.8
   localparam int     SETTLE_CYCLES   = 20;
   localparam int     ITEMS_PER_PHASE = 110;
   localparam longint TIMEOUT_NS      = 64'd3_000_000;

   localparam logic [bcpi_pkg::CSR_DATA_W-1:0] GAIN_MAX = 24'h7FFFFF;
   localparam logic [bcpi_pkg::CSR_DATA_W-1:0] GAIN_MIN = 24'h800000;

   // Indexes past the last register: writes there must leave everything alone
   localparam logic [bcpi_pkg::CSR_IDX_W-1:0] REG_SPARE_A = 3'd5;
   localparam logic [bcpi_pkg::CSR_IDX_W-1:0] REG_SPARE_B = 3'd6;
   localparam logic [bcpi_pkg::CSR_IDX_W-1:0] REG_SPARE_C = 3'd7;

   typedef enum int {MODE_NOISE, MODE_REALISTIC, MODE_DRIFT, MODE_FULL_DRIFT} stim_mode_type;
   typedef enum int {
      SET_TYPICAL, SET_MAX, SET_MIN, SET_RANDOM, SET_MIXED, SET_WIDE_SETPOINT
   } setting_kind_type;

   logic clock;
   logic reset;
   logic                                csr_we;
   logic [bcpi_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [bcpi_pkg::CSR_DATA_W-1:0]     csr_wdata;

   bit idle_enable;        // random idle bursts on both sides when set
   int settings_applied;

   drive_scoreboard sb;

   bcpi_req_if req();
   bcpi_rsp_if rsp();

   balance_pd_speed_pi_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Watchdog: a hung handshake or a missing result ends here
   initial begin
      #(TIMEOUT_NS);
      $display("[balance_pd_speed_pi_controller] ERROR");
      $finish;
   end

   // Result receiver: ready drops in random-length bursts while idling is on.
   // One nonblocking update of ready per edge at most.
   initial begin
      int hold;
      hold = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            rsp.ready <= 1'b0;
            hold = int'($urandom_range(0, 3));
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // Monitor: sees pre-edge values, so bench-driven nonblocking updates never race it.
   // Register writes, tick transfers and result transfers all go to the scoreboard here.
   always @(posedge clock) begin : monitor
      tick_type  seen_tick;
      drive_type seen_drive;
      if (!reset) begin
         if (csr_we) sb.write_reg(csr_index, csr_wdata);
         if (req.valid && req.ready) begin
            seen_tick.tilt_angle  = req.tilt_angle;
            seen_tick.tilt_rate   = req.tilt_rate;
            seen_tick.left_count  = req.left_count;
            seen_tick.right_count = req.right_count;
            sb.note_tick(seen_tick);
         end
         if (rsp.valid && rsp.ready) begin
            seen_drive.motor_drive = rsp.motor_drive;
            seen_drive.angle_term  = rsp.angle_term;
            seen_drive.speed_term  = rsp.speed_term;
            sb.check_result(seen_drive);
         end
      end
   end

   // Random tick. Rate and counts default to full 16-bit range; the angle stays within
   // +-180 deg except in noise mode, which also covers the out-of-range 17-bit codes.
   function automatic tick_type make_tick(input stim_mode_type mode, input int bias);
      tick_type t;
      t.tilt_angle  = (bcpi_pkg::ANGLE_W)'(int'($urandom_range(0, 2 * ANGLE_LIM)) - ANGLE_LIM);
      t.tilt_rate   = (bcpi_pkg::RATE_W)'($urandom);
      t.left_count  = (bcpi_pkg::COUNT_W)'($urandom);
      t.right_count = (bcpi_pkg::COUNT_W)'($urandom);
      case (mode)
         MODE_NOISE: begin
            t.tilt_angle = (bcpi_pkg::ANGLE_W)'($urandom);
         end
         MODE_REALISTIC: begin
            t.tilt_rate   = (bcpi_pkg::RATE_W)'(int'($urandom_range(0, 4000)) - 2000);
            t.left_count  = (bcpi_pkg::COUNT_W)'(int'($urandom_range(0, 600)) - 300);
            t.right_count = (bcpi_pkg::COUNT_W)'(int'($urandom_range(0, 600)) - 300);
         end
         MODE_DRIFT: begin
            // steady wheel speed with jitter: drives the integrator toward its clamp
            t.left_count  = (bcpi_pkg::COUNT_W)'(-bias + int'($urandom_range(0, 1000)) - 500);
            t.right_count = (bcpi_pkg::COUNT_W)'(bias + int'($urandom_range(0, 1000)) - 500);
         end
         default: begin
            // full-scale speed: pushes filter and integral to their extremes
            if (bias >= 0) begin
               t.right_count = (bcpi_pkg::COUNT_W)'(32767 - int'($urandom_range(0, 3)));
               t.left_count  = (bcpi_pkg::COUNT_W)'(-32768 + int'($urandom_range(0, 3)));
            end else begin
               t.right_count = (bcpi_pkg::COUNT_W)'(-32768 + int'($urandom_range(0, 3)));
               t.left_count  = (bcpi_pkg::COUNT_W)'(32767 - int'($urandom_range(0, 3)));
            end
         end
      endcase
      return t;
   endfunction

   // Present one tick and hold it until the transfer. Returns at the accepting edge with
   // valid still high, so a following call keeps it high without a glitch.
   task automatic send_tick(input tick_type t);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.tilt_angle  <= t.tilt_angle;
      req.tilt_rate   <= t.tilt_rate;
      req.left_count  <= t.left_count;
      req.right_count <= t.right_count;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // A throwaway tick for the non-computing phase, then the vector on the computing one
   task automatic send_pair(input int angle, input int rate, input int left, input int right);
      tick_type t;
      send_tick(make_tick(MODE_NOISE, 0));
      t.tilt_angle  = (bcpi_pkg::ANGLE_W)'(angle);
      t.tilt_rate   = (bcpi_pkg::RATE_W)'(rate);
      t.left_count  = (bcpi_pkg::COUNT_W)'(left);
      t.right_count = (bcpi_pkg::COUNT_W)'(right);
      send_tick(t);
   endtask

   // Block is idle once every expected drive is back and the last tick has settled.
   // The first edge lets the monitor log a transfer made at the current one.
   task automatic wait_idle();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bcpi_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bcpi_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_setting(input setting_kind_type kind);
      logic [bcpi_pkg::CSR_DATA_W-1:0] ag, rg, pg, ig, sp;
      case (kind)
         SET_MAX: begin
            ag = GAIN_MAX; rg = GAIN_MAX; pg = GAIN_MAX; ig = GAIN_MAX;
            sp = (bcpi_pkg::CSR_DATA_W)'(ANGLE_LIM);
         end
         SET_MIN: begin
            ag = GAIN_MIN; rg = GAIN_MIN; pg = GAIN_MIN; ig = GAIN_MIN;
            sp = (bcpi_pkg::CSR_DATA_W)'(-ANGLE_LIM);
         end
         SET_RANDOM: begin
            ag = (bcpi_pkg::CSR_DATA_W)'($urandom);
            rg = (bcpi_pkg::CSR_DATA_W)'($urandom);
            pg = (bcpi_pkg::CSR_DATA_W)'($urandom);
            ig = (bcpi_pkg::CSR_DATA_W)'($urandom);
            sp = (bcpi_pkg::CSR_DATA_W)'($urandom);   // only the low 17 bits count
         end
         SET_MIXED: begin
            // speed gains both at max: full-scale speed overflows the speed term
            ag = GAIN_MIN; rg = GAIN_MAX; pg = GAIN_MAX; ig = GAIN_MAX;
            sp = '0;
         end
         SET_WIDE_SETPOINT: begin
            // setpoint at the widest 17-bit codes, beyond +-180 deg
            ag = (bcpi_pkg::CSR_DATA_W)'(int'($urandom_range(0, 153600)) - 76800);
            rg = (bcpi_pkg::CSR_DATA_W)'(int'($urandom_range(0, 2048)) - 1024);
            pg = '0;
            ig = '0;
            sp = $urandom_range(0, 1) ? 24'h00FFFF : 24'h010000;
         end
         default: begin
            // plausible tuning: Q16.8 gains of modest size
            ag = (bcpi_pkg::CSR_DATA_W)'(int'($urandom_range(0, 153600)) - 76800);
            rg = (bcpi_pkg::CSR_DATA_W)'(int'($urandom_range(0, 2048)) - 1024);
            pg = (bcpi_pkg::CSR_DATA_W)'(int'($urandom_range(0, 20480)) - 10240);
            ig = (bcpi_pkg::CSR_DATA_W)'(int'($urandom_range(0, 1024)) - 512);
            sp = (bcpi_pkg::CSR_DATA_W)'(int'($urandom_range(0, 2 * ANGLE_LIM)) - ANGLE_LIM);
         end
      endcase
      write_csr(bcpi_pkg::REG_ANGLE_GAIN, ag);
      write_csr(bcpi_pkg::REG_RATE_GAIN, rg);
      write_csr(bcpi_pkg::REG_SPEED_PGAIN, pg);
      write_csr(bcpi_pkg::REG_SPEED_IGAIN, ig);
      write_csr(bcpi_pkg::REG_SETPOINT, sp);
      if ($urandom_range(0, 1) == 0) write_csr(REG_SPARE_B, (bcpi_pkg::CSR_DATA_W)'($urandom));
      csr_we <= 1'b0;
      @(posedge clock);
      settings_applied++;
   endtask

   // Segments of one stimulus style each; full-scale drift runs long enough
   // (dozens of computing ticks) for the filter to settle near its limit.
   // The last segment is cut short so a phase sends exactly n_items ticks.
   task automatic run_random_phase(input int n_items);
      stim_mode_type mode;
      int            seg_len, bias, r, k;
      k = 0;
      while (k < n_items) begin
         r = int'($urandom_range(0, 9));
         if (r < 2)      mode = MODE_NOISE;
         else if (r < 5) mode = MODE_REALISTIC;
         else if (r < 8) mode = MODE_DRIFT;
         else            mode = MODE_FULL_DRIFT;
         seg_len = (mode == MODE_FULL_DRIFT) ? int'($urandom_range(40, 80))
                                             : int'($urandom_range(10, 50));
         if (seg_len > n_items - k) seg_len = n_items - k;
         bias    = int'($urandom_range(0, 30000)) - 15000;
         repeat (seg_len) begin
            send_tick(make_tick(mode, bias));
            k++;
         end
      end
   endtask

   initial begin
      setting_kind_type plan[8];
      sb = new();
      plan = '{SET_TYPICAL, SET_MAX, SET_RANDOM, SET_MIXED,
               SET_MIN, SET_WIDE_SETPOINT, SET_TYPICAL, SET_RANDOM};
      idle_enable      = 1'b1;
      settings_applied = 0;

      req.valid       <= 1'b0;
      req.tilt_angle  <= '0;
      req.tilt_rate   <= '0;
      req.left_count  <= '0;
      req.right_count <= '0;
      csr_we          <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      reset           <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // Reset gains are zero: first tick after reset gives nothing, the second all zeros
      send_tick(make_tick(MODE_NOISE, 0));
      send_tick(make_tick(MODE_NOISE, 0));
      req.valid <= 1'b0;
      wait_idle();

      // Known tuning; writes to the spare indexes must not disturb any register
      write_csr(bcpi_pkg::REG_ANGLE_GAIN, (bcpi_pkg::CSR_DATA_W)'(25600));   // 100.0
      write_csr(REG_SPARE_A, 24'hFFFFFF);
      write_csr(bcpi_pkg::REG_RATE_GAIN, (bcpi_pkg::CSR_DATA_W)'(-768));     // -3.0
      write_csr(bcpi_pkg::REG_SPEED_PGAIN, (bcpi_pkg::CSR_DATA_W)'(5120));   // 20.0
      write_csr(REG_SPARE_B, 24'h800000);
      write_csr(bcpi_pkg::REG_SPEED_IGAIN, (bcpi_pkg::CSR_DATA_W)'(128));    // 0.5
      write_csr(bcpi_pkg::REG_SETPOINT, (bcpi_pkg::CSR_DATA_W)'(512));       // 2.0 deg
      write_csr(REG_SPARE_C, 24'h5A5A5A);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_applied++;

      // Every vector lands on a computing tick (phase is even after the pair above)
      send_pair(0, 0, 0, 0);
      send_pair(ANGLE_LIM, 32767, -32768, 32767);           // field extremes, max speed
      send_pair(-ANGLE_LIM, -32768, 32767, -32768);
      send_pair(65535, 0, 0, 0);                            // widest 17-bit angle codes
      send_pair(-65536, 1, 1, -1);
      send_pair(512, -1, 0, 0);                             // right on the setpoint
      send_pair(511, 0, 100, 100);                          // fraction truncates to zero
      send_pair(-ANGLE_LIM, 32767, -32768, 32767);          // drive saturates both ways
      send_pair(ANGLE_LIM, -32768, 32767, -32768);
      req.valid <= 1'b0;

      // --- random part: one register setting per phase, written while idle ---
      // Idling is random per phase; the final phase runs at full rate on both sides.
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         apply_setting(plan[p]);
         idle_enable = (p == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
         run_random_phase(ITEMS_PER_PHASE);
         req.valid <= 1'b0;
      end

      wait_idle();
      $display("Run covered %0d ticks, %0d drive values checked, %0d register settings;",
               sb.ticks_seen, sb.drives_checked, settings_applied);
      $display("integrator clamps %0d, term saturations %0d, drive saturations %0d.",
               sb.integ_clamps, sb.term_sats, sb.drive_sats);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("[balance_pd_speed_pi_controller] OK");
      end else begin
         $display("[balance_pd_speed_pi_controller] ERROR");
      end
      $finish;
   end

endmodule
